// ----- design/tspg_pkg.sv -----
// Shared types and constants of the three-axis step pulse generator.
package tspg_pkg;

    localparam int unsigned AXES = 3;

    // Request kinds carried in req_type.
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_MOVE = 2'd1;
    localparam logic [1:0] REQ_STOP = 2'd2;
    localparam logic [1:0] REQ_HOLD = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LOAD_DELAY = 2'd0;
    localparam logic [1:0] CFG_STEP_COEF  = 2'd1;
    localparam logic [1:0] CFG_TICK_SIZE  = 2'd2;

    // Reset values.
    localparam logic [15:0] GRIP_SERVO_RESET   = 16'd2960;
    localparam logic [15:0] ROTATE_SERVO_RESET = 16'd3000;
    localparam logic [15:0] TICK_SIZE_RESET    = 16'd1;
    localparam logic [7:0]  STEPS_RESET        = 8'd1;

    // Axes whose position counts in the inverted sense.
    localparam logic [2:0] AXIS_INVERT = 3'b100;

    // Lowest value of the signed tick countdown.
    localparam logic [17:0] COUNT_MIN = 18'h20000;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] period_x;
        logic [15:0] period_y;
        logic [15:0] period_z;
        logic [2:0]  direction_bits;
        logic [15:0] grip_servo_value;
        logic [15:0] rotate_servo_value;
    } tspg_in_t;

    // Result transaction payload.
    typedef struct packed {
        logic [2:0]         step_pins;
        logic [2:0]         dir_pins;
        logic signed [31:0] position_base;
        logic signed [31:0] position_rear;
        logic signed [31:0] position_fore;
        logic [15:0]        grip_servo_out;
        logic [15:0]        rotate_servo_out;
        logic [2:0]         axes_active;
    } tspg_out_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PUBLISH
    } tspg_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tick;
        logic move;
        logic stop;
        logic hold;
        logic load;
        logic publish;
    } tspg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic out_free;
    } tspg_sts_t;

endpackage

// ----- design/three_axis_step_pulse_generator.sv -----
// Ticks, stop and hold frames: the controller goes from idle to the publish state, and the
// result is registered once the output register is free. Move frames: the three eight-step
// dividers run in parallel, the axes load their results, then the result is published.
// A new item is taken once the previous result sits in the output register.
// Reset (aresetn, synchronous, active low): axes hold one step at period 0,
// servos go to 2960 and 3000, tick size to 1, and no result is pending.
module three_axis_step_pulse_generator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tspg_pkg::tspg_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tspg_pkg::tspg_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    tspg_pkg::tspg_cmd_t cmd;
    tspg_pkg::tspg_sts_t sts;

    // Configuration writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    tspg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .req_type (s_data.req_type),
        .s_ready  (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tspg_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_data   (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

// ----- design/tspg_div.sv -----
// Iterative divider giving a step count saturated to eight bits.
module tspg_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [23:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [7:0]  quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  low_reg, low_next;
    logic [7:0]  quo_reg, quo_next;
    logic [15:0] dsr_reg, dsr_next;
    logic        sat_reg, sat_next;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        fits;

    // One quotient bit per cycle; the upper bits start the remainder and decide saturation.
    always_comb begin
        trial     = {rem_reg, low_reg[7]};
        diff      = trial - {1'b0, dsr_reg};
        fits      = (trial >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        sat_next  = sat_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            rem_next  = dividend[23:8];
            low_next  = dividend[7:0];
            quo_next  = 8'd0;
            dsr_next  = divisor;
            sat_next  = (dividend[23:8] >= divisor);
        end else if (busy_reg) begin
            rem_next = fits ? diff[15:0] : trial[15:0];
            low_next = {low_reg[6:0], 1'b0};
            quo_next = {quo_reg[6:0], fits};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the data path registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        sat_reg <= sat_next;
    end

    assign done     = done_reg;
    assign quotient = sat_reg ? 8'hFF : quo_reg;

endmodule

// ----- design/tspg_ctrl.sv -----
// Controller state machine sequencing ticks, frames and result publication.
module tspg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [1:0]           req_type,
    output logic                 s_ready,
    input  tspg_pkg::tspg_sts_t  sts,
    output tspg_pkg::tspg_cmd_t  cmd
);

    tspg_pkg::tspg_state_t state_reg, state_next;
    logic accept;

    assign accept = s_valid && (state_reg == tspg_pkg::ST_IDLE);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tspg_pkg::ST_IDLE: begin
                if (accept) begin
                    if (req_type == tspg_pkg::REQ_MOVE) begin
                        state_next = tspg_pkg::ST_DIVIDE;
                    end else begin
                        state_next = tspg_pkg::ST_PUBLISH;
                    end
                end
            end
            tspg_pkg::ST_DIVIDE: begin
                if (sts.div_done) begin
                    state_next = tspg_pkg::ST_PUBLISH;
                end
            end
            tspg_pkg::ST_PUBLISH: begin
                if (sts.out_free) begin
                    state_next = tspg_pkg::ST_IDLE;
                end
            end
            default: state_next = tspg_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        s_ready     = (state_reg == tspg_pkg::ST_IDLE);
        cmd         = '0;
        unique case (req_type)
            tspg_pkg::REQ_TICK: cmd.tick = accept;
            tspg_pkg::REQ_MOVE: cmd.move = accept;
            tspg_pkg::REQ_STOP: cmd.stop = accept;
            tspg_pkg::REQ_HOLD: cmd.hold = accept;
            default:            cmd.hold = accept;
        endcase
        cmd.load    = (state_reg == tspg_pkg::ST_DIVIDE) && sts.div_done;
        cmd.publish = (state_reg == tspg_pkg::ST_PUBLISH) && sts.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tspg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/tspg_datapath.sv -----
// Axis state, configuration registers, dividers and the result register.
module tspg_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tspg_pkg::tspg_cmd_t  cmd,
    input  tspg_pkg::tspg_in_t   in_data,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [23:0]          cfg_data,
    input  logic                 m_ready,
    output tspg_pkg::tspg_sts_t  sts,
    output logic                 m_valid,
    output tspg_pkg::tspg_out_t  m_data
);

    localparam int unsigned N = tspg_pkg::AXES;

    logic [15:0] load_delay_reg, tick_size_reg;
    logic [23:0] step_coef_full_reg;

    logic [15:0] period_reg   [N];
    logic [15:0] period_next  [N];
    logic [17:0] count_reg    [N];
    logic [17:0] count_next   [N];
    logic [7:0]  steps_reg    [N];
    logic [7:0]  steps_next   [N];
    logic [N-1:0] level_reg, level_next;
    logic [N-1:0] dir_reg, dir_next;
    logic [N-1:0] dir_in_reg, dir_in_next;
    logic [31:0] pos_reg      [N];
    logic [31:0] pos_next     [N];
    logic [15:0] grip_reg, grip_next;
    logic [15:0] rotate_reg, rotate_next;

    logic [15:0] in_period [N];
    logic [7:0]  quo       [N];
    logic [N-1:0] div_done;

    logic [N-1:0]        active;
    logic                m_valid_reg;
    tspg_pkg::tspg_out_t out_reg;

    assign in_period[0] = in_data.period_x;
    assign in_period[1] = in_data.period_y;
    assign in_period[2] = in_data.period_z;

    // One divider per axis, all launched together by a move frame.
    for (genvar g = 0; g < N; g++) begin : g_div
        tspg_div u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (cmd.move),
            .dividend (step_coef_full_reg),
            .divisor  (in_period[g]),
            .done     (div_done[g]),
            .quotient (quo[g])
        );
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_delay_reg     <= '0;
            step_coef_full_reg <= '0;
            tick_size_reg      <= tspg_pkg::TICK_SIZE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tspg_pkg::CFG_LOAD_DELAY: load_delay_reg     <= cfg_data[15:0];
                tspg_pkg::CFG_STEP_COEF:  step_coef_full_reg <= cfg_data;
                tspg_pkg::CFG_TICK_SIZE:  tick_size_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Per-axis update for ticks, frames and the move load after division.
    always_comb begin
        logic [18:0] diff;
        logic [17:0] cnt;
        logic        up;
        diff = '0;
        cnt  = '0;
        up   = 1'b0;
        for (int a = 0; a < N; a++) begin
            period_next[a] = period_reg[a];
            count_next[a]  = count_reg[a];
            steps_next[a]  = steps_reg[a];
            pos_next[a]    = pos_reg[a];
        end
        level_next  = level_reg;
        dir_next    = dir_reg;
        dir_in_next = dir_in_reg;
        grip_next   = grip_reg;
        rotate_next = rotate_reg;

        if (cmd.tick) begin
            for (int a = 0; a < N; a++) begin
                diff = {count_reg[a][17], count_reg[a]} - {3'b000, tick_size_reg};
                // Saturate below the lowest countdown value.
                if (diff[18] && !diff[17]) begin
                    cnt = tspg_pkg::COUNT_MIN;
                end else begin
                    cnt = diff[17:0];
                end
                if (steps_reg[a] != 8'd0) begin
                    if (cnt[17]) begin
                        level_next[a] = ~level_reg[a];
                        if (!level_reg[a]) begin
                            steps_next[a] = steps_reg[a] - 8'd1;
                        end
                        cnt = cnt + {2'b00, period_reg[a]};
                    end
                    count_next[a] = cnt;
                end
            end
        end

        // Every frame drops the step pins.
        if (cmd.move || cmd.stop || cmd.hold) begin
            level_next = '0;
        end

        if (cmd.move) begin
            for (int a = 0; a < N; a++) begin
                period_next[a] = in_period[a];
            end
            dir_in_next = in_data.direction_bits;
            grip_next   = in_data.grip_servo_value;
            rotate_next = in_data.rotate_servo_value;
        end

        if (cmd.stop) begin
            for (int a = 0; a < N; a++) begin
                steps_next[a] = 8'd0;
            end
        end

        // A zero period only idles its axis.
        if (cmd.load) begin
            for (int a = 0; a < N; a++) begin
                up = dir_in_reg[a] ^ tspg_pkg::AXIS_INVERT[a];
                if (period_reg[a] == 16'd0) begin
                    steps_next[a] = 8'd0;
                end else begin
                    dir_next[a]   = dir_in_reg[a];
                    count_next[a] = {2'b00, period_reg[a]} - {2'b00, load_delay_reg};
                    steps_next[a] = quo[a];
                    if (up) begin
                        pos_next[a] = pos_reg[a] + {24'd0, quo[a]};
                    end else begin
                        pos_next[a] = pos_reg[a] - {24'd0, quo[a]};
                    end
                end
            end
        end
    end

    // Axis and servo state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < N; a++) begin
                period_reg[a] <= '0;
                count_reg[a]  <= '0;
                steps_reg[a]  <= tspg_pkg::STEPS_RESET;
                pos_reg[a]    <= '0;
            end
            level_reg  <= '0;
            dir_reg    <= '0;
            grip_reg   <= tspg_pkg::GRIP_SERVO_RESET;
            rotate_reg <= tspg_pkg::ROTATE_SERVO_RESET;
        end else begin
            for (int a = 0; a < N; a++) begin
                period_reg[a] <= period_next[a];
                count_reg[a]  <= count_next[a];
                steps_reg[a]  <= steps_next[a];
                pos_reg[a]    <= pos_next[a];
            end
            level_reg  <= level_next;
            dir_reg    <= dir_next;
            grip_reg   <= grip_next;
            rotate_reg <= rotate_next;
        end
    end

    always_ff @(posedge aclk) begin
        dir_in_reg <= dir_in_next;
    end

    always_comb begin
        for (int a = 0; a < N; a++) begin
            active[a] = (steps_reg[a] != 8'd0);
        end
    end

    // Result register: holds one transaction while the next item is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            out_reg.step_pins        <= level_reg;
            out_reg.dir_pins         <= dir_reg;
            out_reg.position_base    <= signed'(pos_reg[0]);
            out_reg.position_rear    <= signed'(pos_reg[1]);
            out_reg.position_fore    <= signed'(pos_reg[2]);
            out_reg.grip_servo_out   <= grip_reg;
            out_reg.rotate_servo_out <= rotate_reg;
            out_reg.axes_active      <= active;
        end
    end

    assign sts.div_done = &div_done;
    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = out_reg;

endmodule

// ----- design/tspg_checker.sv -----
// Port-level checker for the step pulse generator and its bind.
module tspg_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input tspg_pkg::tspg_out_t m_data
);

    logic [1:0] pend_reg;
    logic       in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // Count accepted items whose results are still owed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 2'd0;
        end else begin
            pend_reg <= pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // No result is offered right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Every result belongs to an accepted item.
    a_owed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0)
        else $error("result without an accepted item");

    // At most one item in work and one result waiting.
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 2'd3)
        else $error("too many items outstanding");

endmodule

bind three_axis_step_pulse_generator tspg_checker u_tspg_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
